FILE: rtl/luhn_pkg.sv
`timescale 1ns / 1ps

package luhn_pkg;

   localparam int CSR_DATA_WIDTH = 7;

   typedef enum logic [0:0] {
      CSR_MIN_LENGTH = 1'b0,
      CSR_MAX_LENGTH = 1'b1
   } csr_index_type;

   localparam logic [CSR_DATA_WIDTH-1:0] MIN_LENGTH_RESET = 7'd13;
   localparam logic [CSR_DATA_WIDTH-1:0] MAX_LENGTH_RESET = 7'd19;

   typedef enum logic [1:0] {
      VERDICT_VALID    = 2'd0,
      VERDICT_BAD_LEN  = 2'd1,
      VERDICT_NONDIGIT = 2'd2,
      VERDICT_BAD_SUM  = 2'd3
   } verdict_type;

   localparam logic [7:0] COUNT_MAX = 8'd255;

   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0] min_length;
      logic [CSR_DATA_WIDTH-1:0] max_length;
   } cfg_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } item_type;

   // input register contents as seen by the update logic
   typedef struct packed {
      logic     valid;
      item_type item;
   } stage_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [7:0] length;
   } result_type;

   function automatic logic is_blank(input logic [7:0] c);
      is_blank = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic [3:0] add_mod10(input logic [3:0] s, input logic [3:0] v);
      logic [4:0] t;
      t = {1'b0, s} + {1'b0, v};
      add_mod10 = (t >= 5'd10) ? 4'(t - 5'd10) : t[3:0];
   endfunction

endpackage

FILE: rtl/luhn_stream_if.sv
`timescale 1ns / 1ps

interface luhn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

interface luhn_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;
   logic [7:0] length;

   modport source (output valid, output verdict, output length, input ready);
   modport sink   (input valid, input verdict, input length, output ready);
endinterface

FILE: rtl/luhn_input_stage.sv
`timescale 1ns / 1ps

module luhn_input_stage
   import luhn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   luhn_req_if.sink    req_chan,
   input  logic        fire,
   output stage_type   stage
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   // free when empty or when the held word moves on this cycle
   assign req_chan.ready = !valid_ff || fire;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in       = 1'b1;
         item_in.character = req_chan.character;
         item_in.last   = req_chan.last;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

FILE: rtl/luhn_core.sv
`timescale 1ns / 1ps

module luhn_core
   import luhn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  stage_type  stage,
   input  logic       out_free,
   output logic       fire,
   output logic       load,
   output result_type result
);

   logic [7:0] count_ff, count_in;
   logic [3:0] sum_even_ff, sum_even_in;
   logic [3:0] sum_odd_ff, sum_odd_in;
   logic       bad_ff, bad_in;

   logic [7:0] count_n;
   logic [3:0] sum_even_n, sum_odd_n;
   logic       bad_n;
   logic [3:0] digit, doubled, check_sum;
   logic [7:0] c;

   assign c = stage.item.character;

   // a word without last never waits on the result side
   assign fire = stage.valid && (!stage.item.last || out_free);
   assign load = fire && stage.item.last;

   always_comb begin
      digit   = 4'(c - 8'h30);
      doubled = (digit < 4'd5) ? 4'(digit << 1) : 4'((digit << 1) - 4'd9);

      count_n    = count_ff;
      sum_even_n = sum_even_ff;
      sum_odd_n  = sum_odd_ff;
      bad_n      = bad_ff;
      if (!is_blank(c)) begin
         if (is_digit(c)) begin
            if (!count_ff[0]) begin
               sum_even_n = add_mod10(sum_even_ff, doubled);
               sum_odd_n  = add_mod10(sum_odd_ff, digit);
            end else begin
               sum_even_n = add_mod10(sum_even_ff, digit);
               sum_odd_n  = add_mod10(sum_odd_ff, doubled);
            end
         end else begin
            bad_n = 1'b1;
         end
         if (count_ff != COUNT_MAX) begin
            count_n = count_ff + 8'd1;
         end
      end

      // final length parity picks which positions were doubled
      check_sum = count_n[0] ? sum_odd_n : sum_even_n;

      priority if ((count_n < {1'b0, cfg.min_length}) ||
                   (count_n > {1'b0, cfg.max_length})) begin
         result.verdict = VERDICT_BAD_LEN;
      end else if (bad_n) begin
         result.verdict = VERDICT_NONDIGIT;
      end else if (check_sum != 4'd0) begin
         result.verdict = VERDICT_BAD_SUM;
      end else begin
         result.verdict = VERDICT_VALID;
      end
      result.length = count_n;

      count_in    = count_ff;
      sum_even_in = sum_even_ff;
      sum_odd_in  = sum_odd_ff;
      bad_in      = bad_ff;
      if (fire) begin
         if (stage.item.last) begin
            count_in    = 8'd0;
            sum_even_in = 4'd0;
            sum_odd_in  = 4'd0;
            bad_in      = 1'b0;
         end else begin
            count_in    = count_n;
            sum_even_in = sum_even_n;
            sum_odd_in  = sum_odd_n;
            bad_in      = bad_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= 8'd0;
         sum_even_ff <= 4'd0;
         sum_odd_ff  <= 4'd0;
         bad_ff      <= 1'b0;
      end else begin
         count_ff    <= count_in;
         sum_even_ff <= sum_even_in;
         sum_odd_ff  <= sum_odd_in;
         bad_ff      <= bad_in;
      end
   end

endmodule

FILE: rtl/luhn_output_stage.sv
`timescale 1ns / 1ps

module luhn_output_stage
   import luhn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       out_free,
   luhn_rsp_if.source rsp_chan
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.verdict = data_ff.verdict;
   assign rsp_chan.length  = data_ff.length;

endmodule

FILE: rtl/card_number_luhn_validator_top.sv
`timescale 1ns / 1ps

// channel   dir  payload                          handshake
// req_chan  in   character[7:0], last             valid/ready
// rsp_chan  out  verdict[1:0], length[7:0]        valid/ready
// csr_*     in   index[0], write_data[6:0]        write_enable only
//
// One word per cycle while no word with last waits on a stalled rsp: a word is
// held in the input register, the Luhn update and verdict run in one combinational
// pass, and a word with last loads the result register, whose output is rsp.
// Reset (synchronous, high) clears the running sums, count, both valid flags
// and returns min_length/max_length to 13/19.
// A stalled rsp holds only words with last; other words keep flowing until a word with last is held.
module card_number_luhn_validator_top
   import luhn_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   luhn_req_if.sink                  req_chan,
   luhn_rsp_if.source                rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [0:0]                csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_write_data
);

   cfg_type    cfg_ff, cfg_in;
   stage_type  stage;
   logic       fire;
   logic       load;
   logic       out_free;
   result_type result;

   // length limits; the user must write them only while the block is idle, the block does not enforce it
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_LENGTH: cfg_in.min_length = csr_write_data;
            CSR_MAX_LENGTH: cfg_in.max_length = csr_write_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_length <= MIN_LENGTH_RESET;
         cfg_ff.max_length <= MAX_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   luhn_input_stage u_input (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .fire     (fire),
      .stage    (stage)
   );

   // running sums for both doubling parities plus the final verdict
   luhn_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .stage    (stage),
      .out_free (out_free),
      .fire     (fire),
      .load     (load),
      .result   (result)
   );

   luhn_output_stage u_output (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .result   (result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

   // a word with last always produces a result word next cycle
   assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_chan.valid)
      else $error("result word not loaded");

   // a held input word that cannot move keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      (stage.valid && !fire) |=> (stage.valid && $stable(stage.item)))
      else $error("stalled input word lost");

   // a load never lands on a result word that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !load)
      else $error("result word overwritten");

   // reset empties both registers
   assert property (@(posedge clock)
      reset |=> (!stage.valid && !rsp_chan.valid))
      else $error("valid flags not cleared by reset");

endmodule
